[design/chip8_instruction_core_macros.svh]
// Assertion macros for the CHIP-8 instruction core.
// Used by the top level; needs i_clk and i_rst_n in scope.
`ifndef CHIP8_INSTRUCTION_CORE_MACROS_SVH
`define CHIP8_INSTRUCTION_CORE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define C8C_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define C8C_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/c8c_pkg.sv]
// Shared types and constants for the CHIP-8 instruction core.
// No dependencies; used by c8c_alu and chip8_instruction_core.
package c8c_pkg;

    localparam int MEM_AW   = 12;
    localparam int ROW_AW   = 5;
    localparam int SCREEN_W = 64;
    localparam int SCREEN_H = 32;
    localparam int FONT_LEN = 80;
    localparam logic [MEM_AW-1:0] PC_RESET = 12'h200;

    localparam logic [1:0] MODE_WR  = 2'd0;
    localparam logic [1:0] MODE_RUN = 2'd1;
    localparam logic [1:0] MODE_RD  = 2'd2;
    localparam logic [1:0] MODE_ROW = 2'd3;

    localparam logic [7:0] FONT [FONT_LEN] = '{
        8'hF0, 8'h90, 8'h90, 8'h90, 8'hF0, 8'h20, 8'h60, 8'h20, 8'h20, 8'h70,
        8'hF0, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h10, 8'hF0, 8'h10, 8'hF0,
        8'h90, 8'h90, 8'hF0, 8'h10, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'h10, 8'hF0,
        8'hF0, 8'h80, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h10, 8'h20, 8'h40, 8'h40,
        8'hF0, 8'h90, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h90, 8'hF0, 8'h10, 8'hF0,
        8'hF0, 8'h90, 8'hF0, 8'h90, 8'h90, 8'hE0, 8'h90, 8'hE0, 8'h90, 8'hE0,
        8'hF0, 8'h80, 8'h80, 8'h80, 8'hF0, 8'hE0, 8'h90, 8'h90, 8'h90, 8'hE0,
        8'hF0, 8'h80, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h80, 8'hF0, 8'h80, 8'h80
    };

    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE, S_RDM, S_RDF, S_F0, S_F1, S_F2, S_RY, S_VY, S_EXEC,
        S_WRF, S_CLS, S_SPR_ISS, S_SPR_UPD, S_SPR_VF, S_BCD, S_DUMP_RD,
        S_DUMP_WR, S_LOAD_RD, S_LOAD_WR, S_TIMER, S_DONE
    } t_state;

    typedef enum logic [2:0] {
        ALU_PASSB, ALU_ADD, ALU_SUB, ALU_OR, ALU_AND, ALU_XOR, ALU_SHR, ALU_SHL
    } t_alu_op;

    typedef struct packed {
        logic [7:0] res;
        logic       flag;
    } t_alu_res;

endpackage

[design/c8c_alu.sv]
// Shared 8-bit arithmetic, logic and shift unit with a flag output.
// Depends on c8c_pkg for the operation codes and the result struct.
module c8c_alu
    import c8c_pkg::*;
(
    input  t_alu_op    i_op,
    input  logic [7:0] i_a,
    input  logic [7:0] i_b,
    output t_alu_res   o_res
);

    logic [8:0] sum;

    assign sum = {1'b0, i_a} + {1'b0, i_b};

    always_comb begin
        o_res = '0;
        unique case (i_op)
            ALU_PASSB: o_res.res = i_b;
            ALU_ADD: begin
                o_res.res  = sum[7:0];
                o_res.flag = sum[8];
            end
            ALU_SUB: begin
                o_res.res  = i_a - i_b;
                o_res.flag = (i_a >= i_b);
            end
            ALU_OR:  o_res.res = i_a | i_b;
            ALU_AND: o_res.res = i_a & i_b;
            ALU_XOR: o_res.res = i_a ^ i_b;
            ALU_SHR: begin
                o_res.res  = {1'b0, i_a[7:1]};
                o_res.flag = i_a[0];
            end
            ALU_SHL: begin
                o_res.res  = {i_a[6:0], 1'b0};
                o_res.flag = i_a[7];
            end
            default: o_res = '0;
        endcase
    end

endmodule

[design/chip8_instruction_core.sv]
// CHIP-8 instruction core: sequencer, memories and registers around one shared ALU.
// Depends on c8c_pkg, c8c_alu and chip8_instruction_core_macros.svh.
//
//   channel | valid      | ready       | payload
//   in      | i_in_valid | o_in_ready  | i_mode i_address i_data i_keys i_random_byte
//   out     | o_out_valid| i_out_ready | o_cur_pc o_last_opcode o_read_byte o_screen_row
//           |            |             | o_sound_on o_waiting_for_key o_unknown_op
//
// One item at a time. A memory write goes straight to the result; a memory or row read
// passes a read state first. A run item fetches over the single memory port, reads VX
// and VY, executes, may add a flag write, a clear, a sprite, BCD or a dump or load pass,
// then ticks the timers. After reset a clearing pass loads the font and clears all stores.
// The result waits in output registers until taken; no new item enters meanwhile.
`include "chip8_instruction_core_macros.svh"

module chip8_instruction_core
    import c8c_pkg::*;
#(
    parameter int STACK_DEPTH = 16
)
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [1:0]          i_mode,
    input  logic [MEM_AW-1:0]   i_address,
    input  logic [7:0]          i_data,
    input  logic [15:0]         i_keys,
    input  logic [7:0]          i_random_byte,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [MEM_AW-1:0]   o_cur_pc,
    output logic [15:0]         o_last_opcode,
    output logic [7:0]          o_read_byte,
    output logic [SCREEN_W-1:0] o_screen_row,
    output logic                o_sound_on,
    output logic                o_waiting_for_key,
    output logic                o_unknown_op
);

    localparam int SP_W = $clog2(STACK_DEPTH);

    t_state r_state, n_state;
    logic [MEM_AW-1:0] r_pc, n_pc, r_i, n_i, r_cnt, n_cnt;
    logic [SP_W-1:0] r_sp, n_sp;
    logic [7:0] r_dt, n_dt, r_st, n_st, r_vx, n_vx, r_vy, n_vy, r_hi, n_hi;
    logic [7:0] r_tmp, n_tmp, r_rnd, n_rnd, r_rb, n_rb;
    logic [3:0] r_dig, n_dig;
    logic [15:0] r_op, n_op, r_keys, n_keys;
    logic r_flag, n_flag, r_hit, n_hit, r_wait, n_wait, r_unk, n_unk;
    logic [5:0] r_col, n_col;
    logic [ROW_AW-1:0] r_row, n_row;
    logic [SCREEN_W-1:0] r_rowout, n_rowout;

    logic [7:0] r_mem [1 << MEM_AW];
    logic [7:0] r_mem_q;
    logic m_we;
    logic [MEM_AW-1:0] m_addr;
    logic [7:0] m_wd;

    logic [7:0] r_vreg [16];
    logic [7:0] r_v_q;
    logic v_we;
    logic [3:0] v_addr;
    logic [7:0] v_wd;

    logic [SCREEN_W-1:0] r_fb [SCREEN_H];
    logic [SCREEN_W-1:0] r_f_q;
    logic f_we;
    logic [ROW_AW-1:0] f_addr;
    logic [SCREEN_W-1:0] f_wd;

    logic [MEM_AW-1:0] r_stack [STACK_DEPTH];
    logic s_we;
    logic [SP_W-1:0] s_addr;
    logic [MEM_AW-1:0] s_wd;

    t_alu_op alu_op;
    logic [7:0] alu_a, alu_b;
    t_alu_res alu;

    logic in_acc, eq, key_hit, any_key;
    logic [3:0] op_hi, x, y, n, key_idx;
    logic [7:0] nn;
    logic [MEM_AW-1:0] nnn, pc2, i_cnt;
    logic [SP_W-1:0] sp_inc, sp_dec;
    logic [ROW_AW-1:0] line;
    logic [SCREEN_W-1:0] spr;
    logic [2*SCREEN_W-1:0] spr_dbl;

    c8c_alu u_alu (
        .i_op  (alu_op),
        .i_a   (alu_a),
        .i_b   (alu_b),
        .o_res (alu)
    );

    assign op_hi   = r_op[15:12];
    assign x       = r_op[11:8];
    assign y       = r_op[7:4];
    assign n       = r_op[3:0];
    assign nn      = r_op[7:0];
    assign nnn     = r_op[MEM_AW-1:0];
    assign pc2     = r_pc + 12'd2;
    assign i_cnt   = r_i + r_cnt;
    assign eq      = (alu.res == 8'd0);
    assign key_hit = r_keys[r_vx[3:0]];
    assign any_key = |r_keys;
    assign sp_inc  = (r_sp == SP_W'(STACK_DEPTH - 1)) ? '0 : r_sp + 1'b1;
    assign sp_dec  = (r_sp == '0) ? SP_W'(STACK_DEPTH - 1) : r_sp - 1'b1;
    assign line    = r_row + r_cnt[ROW_AW-1:0];
    assign spr_dbl = {r_mem_q, 56'd0, r_mem_q, 56'd0} >> r_col;
    assign spr     = spr_dbl[SCREEN_W-1:0];
    assign in_acc  = i_in_valid && o_in_ready;

    always_comb begin
        key_idx = 4'd0;
        for (int k = 15; k >= 0; k--) begin
            if (r_keys[k]) key_idx = 4'(k);
        end
    end

    always_comb begin
        alu_a  = r_vx;
        alu_b  = r_vy;
        alu_op = ALU_PASSB;
        if (r_state == S_BCD) begin
            alu_a  = r_tmp;
            alu_b  = (r_cnt == 12'd0) ? 8'd100 : 8'd10;
            alu_op = ALU_SUB;
        end else begin
            case (op_hi)
                4'h3, 4'h4: begin
                    alu_b  = nn;
                    alu_op = ALU_XOR;
                end
                4'h5, 4'h9: alu_op = ALU_XOR;
                4'h7: begin
                    alu_b  = nn;
                    alu_op = ALU_ADD;
                end
                4'hC: begin
                    alu_a  = r_rnd;
                    alu_b  = nn;
                    alu_op = ALU_AND;
                end
                4'h8: begin
                    case (n)
                        4'h1: alu_op = ALU_OR;
                        4'h2: alu_op = ALU_AND;
                        4'h3: alu_op = ALU_XOR;
                        4'h4: alu_op = ALU_ADD;
                        4'h5: alu_op = ALU_SUB;
                        4'h6: alu_op = ALU_SHR;
                        4'h7: begin
                            alu_a  = r_vy;
                            alu_b  = r_vx;
                            alu_op = ALU_SUB;
                        end
                        4'hE: alu_op = ALU_SHL;
                        default: alu_op = ALU_PASSB;
                    endcase
                end
                default: alu_op = ALU_PASSB;
            endcase
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: if (r_cnt == 12'hFFF) n_state = S_IDLE;
            S_IDLE: begin
                if (in_acc) begin
                    unique case (i_mode)
                        MODE_WR:  n_state = S_DONE;
                        MODE_RUN: n_state = S_F0;
                        MODE_RD:  n_state = S_RDM;
                        MODE_ROW: n_state = S_RDF;
                        default:  n_state = S_DONE;
                    endcase
                end
            end
            S_RDM, S_RDF: n_state = S_DONE;
            S_F0:    n_state = S_F1;
            S_F1:    n_state = S_F2;
            S_F2:    n_state = S_RY;
            S_RY:    n_state = S_VY;
            S_VY:    n_state = S_EXEC;
            S_EXEC: begin
                n_state = S_TIMER;
                case (op_hi)
                    4'h0: if (r_op == 16'h00E0) n_state = S_CLS;
                    4'h8: begin
                        case (n)
                            4'h4, 4'h5, 4'h6, 4'h7, 4'hE: n_state = S_WRF;
                            default: n_state = S_TIMER;
                        endcase
                    end
                    4'hD: n_state = (n == 4'd0) ? S_SPR_VF : S_SPR_ISS;
                    4'hF: begin
                        case (nn)
                            8'h33:   n_state = S_BCD;
                            8'h55:   n_state = S_DUMP_RD;
                            8'h65:   n_state = S_LOAD_RD;
                            default: n_state = S_TIMER;
                        endcase
                    end
                    default: n_state = S_TIMER;
                endcase
            end
            S_WRF:     n_state = S_TIMER;
            S_CLS:     if (r_cnt == 12'(SCREEN_H - 1)) n_state = S_TIMER;
            S_SPR_ISS: n_state = S_SPR_UPD;
            S_SPR_UPD: n_state = (r_cnt[3:0] == n - 4'd1) ? S_SPR_VF : S_SPR_ISS;
            S_SPR_VF:  n_state = S_TIMER;
            S_BCD:     if (r_cnt == 12'd2) n_state = S_TIMER;
            S_DUMP_RD: n_state = S_DUMP_WR;
            S_DUMP_WR: n_state = (r_cnt[3:0] == x) ? S_TIMER : S_DUMP_RD;
            S_LOAD_RD: n_state = S_LOAD_WR;
            S_LOAD_WR: n_state = (r_cnt[3:0] == x) ? S_TIMER : S_LOAD_RD;
            S_TIMER:   n_state = S_DONE;
            S_DONE:    if (i_out_ready) n_state = S_IDLE;
            default:   n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_pc = r_pc;   n_i = r_i;     n_cnt = r_cnt;   n_sp = r_sp;
        n_dt = r_dt;   n_st = r_st;   n_vx = r_vx;     n_vy = r_vy;
        n_hi = r_hi;   n_tmp = r_tmp; n_rnd = r_rnd;   n_rb = r_rb;
        n_dig = r_dig; n_op = r_op;   n_keys = r_keys; n_flag = r_flag;
        n_hit = r_hit; n_wait = r_wait; n_unk = r_unk; n_col = r_col;
        n_row = r_row; n_rowout = r_rowout;
        m_we = 1'b0; m_addr = r_pc; m_wd = 8'd0;
        v_we = 1'b0; v_addr = x;    v_wd = alu.res;
        f_we = 1'b0; f_addr = line; f_wd = '0;
        s_we = 1'b0; s_addr = r_sp; s_wd = r_pc;
        unique case (r_state)
            S_CLEAR: begin
                m_we   = 1'b1;
                m_addr = r_cnt;
                m_wd   = (r_cnt < 12'(FONT_LEN)) ? FONT[r_cnt[6:0]] : 8'd0;
                v_we   = (r_cnt < 12'd16);
                v_addr = r_cnt[3:0];
                v_wd   = 8'd0;
                s_we   = (r_cnt < 12'(STACK_DEPTH));
                s_addr = r_cnt[SP_W-1:0];
                s_wd   = '0;
                f_we   = (r_cnt < 12'(SCREEN_H));
                f_addr = r_cnt[ROW_AW-1:0];
                n_cnt  = r_cnt + 12'd1;
            end
            S_IDLE: begin
                if (in_acc) begin
                    n_keys   = i_keys;
                    n_rnd    = i_random_byte;
                    n_op     = 16'd0;
                    n_rb     = 8'd0;
                    n_rowout = '0;
                    n_wait   = 1'b0;
                    n_unk    = 1'b0;
                    m_addr   = i_address;
                    m_wd     = i_data;
                    m_we     = (i_mode == MODE_WR);
                    f_addr   = i_address[ROW_AW-1:0];
                end
            end
            S_RDM: n_rb = r_mem_q;
            S_RDF: n_rowout = r_f_q;
            S_F0:  m_addr = r_pc;
            S_F1: begin
                m_addr = r_pc + 12'd1;
                n_hi   = r_mem_q;
            end
            S_F2: begin
                n_op   = {r_hi, r_mem_q};
                n_pc   = pc2;
                v_addr = (r_hi[7:4] == 4'hB) ? 4'd0 : r_hi[3:0];
            end
            S_RY: begin
                v_addr = y;
                n_vx   = r_v_q;
            end
            S_VY: n_vy = r_v_q;
            S_EXEC: begin
                n_cnt = 12'd0;
                unique case (op_hi)
                    4'h0: begin
                        if (r_op == 16'h00EE) begin
                            n_sp = sp_dec;
                            n_pc = r_stack[sp_dec];
                        end else if (r_op != 16'h00E0) begin
                            n_unk = 1'b1;
                        end
                    end
                    4'h1: n_pc = nnn;
                    4'h2: begin
                        s_we = 1'b1;
                        n_sp = sp_inc;
                        n_pc = nnn;
                    end
                    4'h3: if (eq) n_pc = pc2;
                    4'h4: if (!eq) n_pc = pc2;
                    4'h5: begin
                        if (n != 4'd0) n_unk = 1'b1;
                        else if (eq) n_pc = pc2;
                    end
                    4'h6: begin
                        v_we = 1'b1;
                        v_wd = nn;
                    end
                    4'h7, 4'hC: v_we = 1'b1;
                    4'h8: begin
                        case (n)
                            4'h0, 4'h1, 4'h2, 4'h3, 4'h4, 4'h5, 4'h6, 4'h7, 4'hE: begin
                                v_we   = 1'b1;
                                n_flag = alu.flag;
                            end
                            default: n_unk = 1'b1;
                        endcase
                    end
                    4'h9: begin
                        if (n != 4'd0) n_unk = 1'b1;
                        else if (!eq) n_pc = pc2;
                    end
                    4'hA: n_i = nnn;
                    4'hB: n_pc = nnn + {4'd0, r_vx};
                    4'hD: begin
                        n_col = r_vx[5:0];
                        n_row = r_vy[ROW_AW-1:0];
                        n_hit = 1'b0;
                    end
                    4'hE: begin
                        if (nn == 8'h9E) begin
                            if (key_hit) n_pc = pc2;
                        end else if (nn == 8'hA1) begin
                            if (!key_hit) n_pc = pc2;
                        end else begin
                            n_unk = 1'b1;
                        end
                    end
                    4'hF: begin
                        case (nn)
                            8'h07: begin
                                v_we = 1'b1;
                                v_wd = r_dt;
                            end
                            8'h0A: begin
                                if (any_key) begin
                                    v_we = 1'b1;
                                    v_wd = {4'd0, key_idx};
                                end else begin
                                    n_pc   = r_pc - 12'd2;
                                    n_wait = 1'b1;
                                end
                            end
                            8'h15: n_dt = r_vx;
                            8'h18: n_st = r_vx;
                            8'h1E: n_i = r_i + {4'd0, r_vx};
                            8'h29: n_i = {6'd0, r_vx[3:0], 2'd0} + {8'd0, r_vx[3:0]};
                            8'h33: begin
                                n_tmp = r_vx;
                                n_dig = 4'd0;
                            end
                            8'h55, 8'h65: n_cnt = 12'd0;
                            default: n_unk = 1'b1;
                        endcase
                    end
                    default: n_unk = 1'b1;
                endcase
            end
            S_WRF: begin
                v_we   = 1'b1;
                v_addr = 4'hF;
                v_wd   = {7'd0, r_flag};
            end
            S_CLS: begin
                f_we   = 1'b1;
                f_addr = r_cnt[ROW_AW-1:0];
                n_cnt  = r_cnt + 12'd1;
            end
            S_SPR_ISS: m_addr = i_cnt;
            S_SPR_UPD: begin
                f_we  = 1'b1;
                f_wd  = r_f_q ^ spr;
                n_hit = r_hit | (|(r_f_q & spr));
                n_cnt = r_cnt + 12'd1;
            end
            S_SPR_VF: begin
                v_we   = 1'b1;
                v_addr = 4'hF;
                v_wd   = {7'd0, r_hit};
            end
            S_BCD: begin
                m_addr = i_cnt;
                if (r_cnt == 12'd2) begin
                    m_we = 1'b1;
                    m_wd = r_tmp;
                end else if (alu.flag) begin
                    n_tmp = alu.res;
                    n_dig = r_dig + 4'd1;
                end else begin
                    m_we  = 1'b1;
                    m_wd  = {4'd0, r_dig};
                    n_dig = 4'd0;
                    n_cnt = r_cnt + 12'd1;
                end
            end
            S_DUMP_RD: v_addr = r_cnt[3:0];
            S_DUMP_WR: begin
                m_we   = 1'b1;
                m_addr = i_cnt;
                m_wd   = r_v_q;
                n_cnt  = r_cnt + 12'd1;
            end
            S_LOAD_RD: m_addr = i_cnt;
            S_LOAD_WR: begin
                v_we   = 1'b1;
                v_addr = r_cnt[3:0];
                v_wd   = r_mem_q;
                n_cnt  = r_cnt + 12'd1;
            end
            S_TIMER: begin
                if (r_dt != 8'd0) n_dt = r_dt - 8'd1;
                if (r_st != 8'd0) n_st = r_st - 8'd1;
            end
            S_DONE: n_cnt = r_cnt;
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (m_we) r_mem[m_addr] <= m_wd;
        r_mem_q <= r_mem[m_addr];
    end

    always_ff @(posedge i_clk) begin
        if (v_we) r_vreg[v_addr] <= v_wd;
        r_v_q <= r_vreg[v_addr];
    end

    always_ff @(posedge i_clk) begin
        if (f_we) r_fb[f_addr] <= f_wd;
        r_f_q <= r_fb[f_addr];
    end

    always_ff @(posedge i_clk) begin
        if (s_we) r_stack[s_addr] <= s_wd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_cnt   <= '0;
            r_pc    <= PC_RESET;
            r_i     <= '0;
            r_sp    <= '0;
            r_dt    <= '0;
            r_st    <= '0;
            r_op    <= '0;
            r_wait  <= 1'b0;
            r_unk   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_pc    <= n_pc;
            r_i     <= n_i;
            r_sp    <= n_sp;
            r_dt    <= n_dt;
            r_st    <= n_st;
            r_op    <= n_op;
            r_wait  <= n_wait;
            r_unk   <= n_unk;
        end
    end

    always_ff @(posedge i_clk) begin
        r_vx     <= n_vx;
        r_vy     <= n_vy;
        r_hi     <= n_hi;
        r_tmp    <= n_tmp;
        r_rnd    <= n_rnd;
        r_rb     <= n_rb;
        r_dig    <= n_dig;
        r_keys   <= n_keys;
        r_flag   <= n_flag;
        r_hit    <= n_hit;
        r_col    <= n_col;
        r_row    <= n_row;
        r_rowout <= n_rowout;
    end

    assign o_in_ready        = (r_state == S_IDLE);
    assign o_out_valid       = (r_state == S_DONE);
    assign o_cur_pc          = r_pc;
    assign o_last_opcode     = r_op;
    assign o_read_byte       = r_rb;
    assign o_screen_row      = r_rowout;
    assign o_sound_on        = (r_st != 8'd0);
    assign o_waiting_for_key = r_wait;
    assign o_unknown_op      = r_unk;

    `C8C_ASSERT_NOW(a_one_item, o_out_valid, !o_in_ready,
        "New item could be taken while a result is pending.")
    `C8C_ASSERT_NEXT(a_write_done, in_acc && (i_mode == MODE_WR), o_out_valid,
        "Memory write item did not complete in one cycle.")
    `C8C_ASSERT_NOW(a_wait_op,
        o_out_valid && o_waiting_for_key,
        (o_last_opcode[15:12] == 4'hF) && (o_last_opcode[7:0] == 8'h0A),
        "Key wait reported for an opcode other than FX0A.")

endmodule
